@@ sv/vlmr_pkg.sv @@
// shared types and constants for the variable-length message ring
`timescale 1ns / 1ps
`default_nettype none
package vlmr_pkg;

	// defaults and fixed sizes
	localparam int RING_DEPTH_DEF    = 256;
	localparam int WORD_BYTES        = 4;
	localparam int MAX_MESSAGE_WORDS = 32;
	localparam int MAX_BYTES         = MAX_MESSAGE_WORDS * WORD_BYTES;
	localparam int DATA_W            = 32;
	localparam int BYTES_W           = 8;
	localparam int LANES             = DATA_W / 8;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NO_ROOM  = 2'd2,
		ST_ZERO_LEN = 2'd3
	} status_t;

	// operation kind decided by the front
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_READ = 1'b1
	} op_kind_t;

	// one queued operation
	typedef struct packed {
		op_kind_t            kind;
		logic [BYTES_W-1:0]  byte_count;
		logic [DATA_W-1:0]   data_word;
		logic                last_word;
	} op_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE    = 3'd0,
		BK_CM_SIZE = 3'd1,
		BK_CM_NEXT = 3'd2,
		BK_RD_SIZE = 3'd3,
		BK_RD_NEXT = 3'd4,
		BK_RD_WORD = 3'd5
	} back_state_t;

endpackage
`default_nettype wire

@@ sv/vlmr_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module vlmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/vlmr_front.sv @@
// front end: takes input transfers, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module vlmr_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic [vlmr_pkg::BYTES_W-1:0]  byte_count,
	input  wire logic [vlmr_pkg::DATA_W-1:0]   data_word,
	input  wire logic                          last_word,
	output logic                               op_valid,
	output vlmr_pkg::op_t                      op,
	input  wire logic                          op_pop
);
	import vlmr_pkg::*;

	op_t        ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        new_op;

	// classify the incoming transfer
	always_comb begin
		new_op.kind       = command ? OP_READ : OP_PUSH;
		new_op.byte_count = byte_count;
		new_op.data_word  = data_word;
		new_op.last_word  = last_word;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign op_valid = (cnt_q != 2'd0);
	assign op       = ent_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= new_op;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (op_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, op_pop};
		end
	end
endmodule
`default_nettype wire

@@ sv/vlmr_back.sv @@
// back end: ring bookkeeping, message commit and message read-out
`timescale 1ns / 1ps
`default_nettype none
module vlmr_back #(
	parameter int RING_DEPTH = vlmr_pkg::RING_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              op_valid,
	input  wire vlmr_pkg::op_t                     op,
	output logic                                   op_pop,
	output logic                                   mem_we,
	output logic [$clog2(RING_DEPTH)-1:0]          mem_waddr,
	output logic [vlmr_pkg::DATA_W-1:0]            mem_wdata,
	output logic [$clog2(RING_DEPTH)-1:0]          mem_raddr,
	input  wire logic [vlmr_pkg::DATA_W-1:0]       mem_rdata,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [vlmr_pkg::DATA_W-1:0]            read_word,
	output logic [vlmr_pkg::BYTES_W-1:0]           read_bytes,
	output logic                                   final_word,
	output logic [1:0]                             status,
	output logic                                   ring_empty
);
	import vlmr_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int SW = AW + 8;

	back_state_t        state_q, state_d;
	logic [AW-1:0]      ri_q, ri_d, wi_q, wi_d, cur_q, cur_d, rd_addr_q, rd_addr_d;
	logic [AW-1:0]      next_q, next_d;
	logic [7:0]         cnt_q, cnt_d, obc_q, obc_d, size_q, size_d;
	logic [7:0]         nwords_q, nwords_d, full_q, full_d, idx_q, idx_d;
	logic [3:0]         rem_q, rem_d;
	logic               open_q, open_d, rej_q, rej_d;

	logic               out_valid_q, out_free;
	logic [DATA_W-1:0]  word_q;
	logic [7:0]         bytes_q;
	logic               fin_q, empty_q;
	status_t            status_q;

	logic               emit;
	logic [DATA_W-1:0]  e_word;
	logic [7:0]         e_bytes;
	logic               e_fin, e_empty;
	status_t            e_status;

	// push classification signals
	logic [7:0]         eff_obc, need;
	logic [8:0]         words;
	logic [AW-1:0]      base, eff_cur, commit_next;
	logic [7:0]         eff_cnt;
	logic [SW-1:0]      room_gap;
	logic               room_bad, new_rej, eff_rej;
	logic               is_push, is_read;
	logic [7:0]         rd_full, rd_n;
	logic [3:0]         rd_rem;
	logic               word_last;

	// modular add of a small offset to a ring index
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [7:0] k);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(k);
		if (s >= SW'(RING_DEPTH)) begin
			s = s - SW'(RING_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign op_pop   = (state_q == BK_IDLE) && op_valid && out_free;
	assign is_push  = op_pop && (op.kind == OP_PUSH);
	assign is_read  = op_pop && (op.kind == OP_READ);

	// room check and write slot selection for a pushed word
	always_comb begin
		eff_obc  = open_q ? obc_q : op.byte_count;
		need     = 8'(op.byte_count / WORD_BYTES) + 8'd3;
		base     = ring_add(wi_q, 8'd2);
		room_gap = SW'(ri_q) - SW'(wi_q);
		if (ri_q < wi_q) begin
			room_gap = room_gap + SW'(RING_DEPTH);
		end
		if (room_gap == '0) begin
			room_bad = (SW'(need) >= SW'(RING_DEPTH));
		end else begin
			room_bad = (room_gap <= SW'(need));
		end
		new_rej = (op.byte_count == 8'd0) || (int'(op.byte_count) > MAX_BYTES) || room_bad;
		eff_rej = open_q ? rej_q : new_rej;
		eff_cur = open_q ? cur_q : base;
		eff_cnt = open_q ? cnt_q : 8'd0;
		words   = 9'((9'(eff_obc) + 9'(WORD_BYTES - 1)) / WORD_BYTES);
		commit_next = ring_add(wi_q, 8'(obc_q / WORD_BYTES) + 8'd3);
	end

	// read-out length decode from the stored size word
	always_comb begin
		rd_full = 8'(size_q / WORD_BYTES);
		rd_rem  = 4'(size_q % WORD_BYTES);
		rd_n    = rd_full + ((rd_rem != 4'd0) ? 8'd1 : 8'd0);
		if (int'(rd_n) > MAX_MESSAGE_WORDS) begin
			rd_n = 8'(MAX_MESSAGE_WORDS);
		end
		word_last = (idx_q + 8'd1 == nwords_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (is_push && op.last_word && !eff_rej) begin
					state_d = BK_CM_SIZE;
				end else if (is_read && (ri_q != wi_q)) begin
					state_d = BK_RD_SIZE;
				end
			end
			BK_CM_SIZE: state_d = BK_CM_NEXT;
			BK_CM_NEXT: state_d = BK_IDLE;
			BK_RD_SIZE: state_d = BK_RD_NEXT;
			BK_RD_NEXT: state_d = (rd_n == 8'd0) ? BK_IDLE : BK_RD_WORD;
			BK_RD_WORD: begin
				if (out_free && word_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath and result generation
	always_comb begin
		ri_d = ri_q; wi_d = wi_q; cur_d = cur_q; cnt_d = cnt_q;
		obc_d = obc_q; open_d = open_q; rej_d = rej_q;
		rd_addr_d = rd_addr_q; size_d = size_q; next_d = next_q;
		nwords_d = nwords_q; full_d = full_q; rem_d = rem_q; idx_d = idx_q;
		mem_we = 1'b0; mem_waddr = wi_q; mem_wdata = '0;
		emit = 1'b0; e_word = '0; e_bytes = '0; e_fin = 1'b1;
		e_status = ST_OK; e_empty = (ri_q == wi_q);
		unique case (state_q)
			BK_IDLE: begin
				rd_addr_d = ri_q;
				if (is_push) begin
					if (!open_q) begin
						obc_d = op.byte_count;
						rej_d = new_rej;
					end
					open_d = 1'b1;
					cur_d  = eff_cur;
					cnt_d  = eff_cnt;
					if (!eff_rej && (9'(eff_cnt) < words)) begin
						mem_we    = 1'b1;
						mem_waddr = eff_cur;
						mem_wdata = op.data_word;
						cur_d     = ring_add(eff_cur, 8'd1);
						cnt_d     = eff_cnt + 8'd1;
					end
					if (op.last_word) begin
						open_d = 1'b0;
						if (eff_rej) begin
							emit     = 1'b1;
							e_status = (eff_obc == 8'd0) ? ST_ZERO_LEN : ST_NO_ROOM;
						end
					end
				end else if (is_read && (ri_q == wi_q)) begin
					emit     = 1'b1;
					e_status = ST_EMPTY;
				end
			end
			BK_CM_SIZE: begin
				mem_we    = 1'b1;
				mem_waddr = wi_q;
				mem_wdata = DATA_W'(obc_q);
			end
			BK_CM_NEXT: begin
				mem_we    = 1'b1;
				mem_waddr = ring_add(wi_q, 8'd1);
				mem_wdata = DATA_W'(commit_next);
				wi_d      = commit_next;
				emit      = 1'b1;
				e_empty   = (ri_q == commit_next);
			end
			BK_RD_SIZE: begin
				size_d    = mem_rdata[7:0];
				rd_addr_d = ring_add(rd_addr_q, 8'd1);
			end
			BK_RD_NEXT: begin
				next_d    = mem_rdata[AW-1:0];
				full_d    = rd_full;
				rem_d     = rd_rem;
				nwords_d  = rd_n;
				idx_d     = 8'd0;
				rd_addr_d = ring_add(rd_addr_q, 8'd1);
				if (rd_n == 8'd0) begin
					ri_d    = mem_rdata[AW-1:0];
					emit    = 1'b1;
					e_bytes = size_q;
					e_empty = (mem_rdata[AW-1:0] == wi_q);
				end
			end
			BK_RD_WORD: begin
				e_word = mem_rdata;
				if ((idx_q == full_q) && (rem_q != 4'd0)) begin
					for (int k = 0; k < LANES; k++) begin
						if (k >= int'(rem_q)) begin
							e_word[k*8 +: 8] = 8'd0;
						end
					end
				end
				e_bytes = size_q;
				e_fin   = word_last;
				e_empty = (next_q == wi_q);
				if (out_free) begin
					emit = 1'b1;
					if (word_last) begin
						ri_d = next_q;
					end else begin
						idx_d     = idx_q + 8'd1;
						rd_addr_d = ring_add(rd_addr_q, 8'd1);
					end
				end
			end
			default: ;
		endcase
	end

	assign mem_raddr = rd_addr_d;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ri_q        <= '0;
			wi_q        <= '0;
			cur_q       <= '0;
			cnt_q       <= '0;
			obc_q       <= '0;
			open_q      <= 1'b0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ri_q    <= ri_d;
			wi_q    <= wi_d;
			cur_q   <= cur_d;
			cnt_q   <= cnt_d;
			obc_q   <= obc_d;
			open_q  <= open_d;
			rej_q   <= rej_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read-out working registers and result register
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr_d;
		size_q    <= size_d;
		next_q    <= next_d;
		nwords_q  <= nwords_d;
		full_q    <= full_d;
		rem_q     <= rem_d;
		idx_q     <= idx_d;
		if (emit) begin
			word_q   <= e_word;
			bytes_q  <= e_bytes;
			fin_q    <= e_fin;
			status_q <= e_status;
			empty_q  <= e_empty;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_word  = word_q;
	assign read_bytes = bytes_q;
	assign final_word = fin_q;
	assign status     = status_q;
	assign ring_empty = empty_q;
endmodule
`default_nettype wire

@@ sv/variable_length_message_ring.sv @@
// A pushed word is written when the back end takes it from the front queue; a commit status
// follows the size and link writes, and a drop status is registered with the last word.
// Throughput: one pushed word per cycle while the output is not stalled; a committing last word
// holds the back end for two single-port writes (size and link). A read presents its first word
// after size and link are read via the registered ram port, then one per cycle unless stalled.
// Reset clears indices and control at once; ring contents are not cleared, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module variable_length_message_ring #(
	parameter int RING_DEPTH = vlmr_pkg::RING_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          command,
	input  wire logic [vlmr_pkg::BYTES_W-1:0]  byte_count,
	input  wire logic [vlmr_pkg::DATA_W-1:0]   data_word,
	input  wire logic                          last_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [vlmr_pkg::DATA_W-1:0]        read_word,
	output logic [vlmr_pkg::BYTES_W-1:0]       read_bytes,
	output logic                               final_word,
	output logic [1:0]                         status,
	output logic                               ring_empty
);
	import vlmr_pkg::*;

	localparam int AW = $clog2(RING_DEPTH);

	logic              op_valid, op_pop;
	op_t               op;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	// input queue and classification
	vlmr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.byte_count (byte_count),
		.data_word  (data_word),
		.last_word  (last_word),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop)
	);

	// ring bookkeeping and read-out
	vlmr_back #(.RING_DEPTH(RING_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op         (op),
		.op_pop     (op_pop),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_word  (read_word),
		.read_bytes (read_bytes),
		.final_word (final_word),
		.status     (status),
		.ring_empty (ring_empty)
	);

	// ring word store
	vlmr_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule
`default_nettype wire
